@@ rtl/coo_duplicate_merge_unit_defines.svh @@
// Assertion macros for the duplicate merge unit's top-level RTL file.
`ifndef COO_DUPLICATE_MERGE_UNIT_DEFINES_SVH
`define COO_DUPLICATE_MERGE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on aclk while aresetn is high.
`define CDM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk while aresetn is high.
`define CDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cdm_pkg.sv @@
// Types and constants shared by the duplicate merge unit's modules.
package cdm_pkg;

    // Width of the running sum and of the divider's dividend.
    localparam int ACC_WIDTH = 64;

    typedef enum logic [2:0] {
        POL_SUM  = 3'd0,
        POL_AVG  = 3'd1,
        POL_MAX  = 3'd2,
        POL_MIN  = 3'd3,
        POL_LAST = 3'd4
    } cdm_policy_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // take the input word this cycle
        logic start_div;   // start dividing the snapshot sum by its count
        logic load_out;    // load the output register from the snapshot
        logic sel_div;     // output value comes from the divider quotient
        logic snap_final;  // snapshot the pending entry as stream end, clear it
    } cdm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic snap_taken;  // the input word would produce a result
        logic fin_later;   // the input word would need a second, final result
        logic policy_avg;  // average policy is in force
        logic div_done;    // divider finished this cycle
        logic div_busy;    // divider is running
        logic out_free;    // output register can be loaded this cycle
    } cdm_status_t;

endpackage

@@ rtl/cdm_divider.sv @@
// Restoring divider: one quotient bit per cycle for the average policy.
module cdm_divider #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cdm_pkg::ACC_WIDTH-1:0]  dividend,
    input  logic [COUNT_WIDTH-1:0]         divisor,
    output logic [cdm_pkg::ACC_WIDTH-1:0]  quotient,
    output logic                           busy,
    output logic                           done
);

    localparam int STEP_W = $clog2(cdm_pkg::ACC_WIDTH);

    logic [cdm_pkg::ACC_WIDTH-1:0] quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0]        rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0]        dvs_reg, dvs_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [COUNT_WIDTH:0]          trial;
    logic [COUNT_WIDTH:0]          diff;
    logic                          last_step;

    assign trial     = {rem_reg, quo_reg[cdm_pkg::ACC_WIDTH-1]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign last_step = (step_reg == STEP_W'(cdm_pkg::ACC_WIDTH - 1));

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Subtract when the shifted remainder reaches the divisor.
            if (!diff[COUNT_WIDTH]) begin
                rem_next = diff[COUNT_WIDTH-1:0];
                quo_next = {quo_reg[cdm_pkg::ACC_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = trial[COUNT_WIDTH-1:0];
                quo_next = {quo_reg[cdm_pkg::ACC_WIDTH-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

@@ rtl/cdm_ctrl.sv @@
// Controller state machine that sequences acceptance, division and output.
module cdm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cdm_pkg::cdm_status_t status,
    output cdm_pkg::cdm_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_PUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_later_reg, fin_later_next;

    always_comb begin
        state_next     = state_reg;
        fin_later_next = fin_later_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    if (status.snap_taken) begin
                        fin_later_next = status.fin_later;
                        state_next     = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                if (status.policy_avg) begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end else if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    if (fin_later_reg) begin
                        cmd.snap_final = 1'b1;
                        fin_later_next = 1'b0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.sel_div  = 1'b1;
                    if (fin_later_reg) begin
                        cmd.snap_final = 1'b1;
                        fin_later_next = 1'b0;
                        state_next     = ST_CALC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fin_later_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fin_later_reg <= fin_later_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

@@ rtl/cdm_datapath.sv @@
// Datapath: pending entry, merge logic, result snapshot, divider and output register.
module cdm_datapath #(
    parameter int INDEX_WIDTH = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [2:0]               cfg_wr_data,
    input  logic [INDEX_WIDTH-1:0]   in_row,
    input  logic [INDEX_WIDTH-1:0]   in_col,
    input  logic [VALUE_WIDTH-1:0]   in_value,
    input  logic                     in_final,
    input  cdm_pkg::cdm_cmd_t        cmd,
    output cdm_pkg::cdm_status_t     status,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [INDEX_WIDTH-1:0]   out_row,
    output logic [INDEX_WIDTH-1:0]   out_col,
    output logic [VALUE_WIDTH-1:0]   out_value,
    output logic [COUNT_WIDTH-1:0]   out_count,
    output logic                     out_end
);

    localparam int AW = cdm_pkg::ACC_WIDTH;
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [AW-1:0] VAL_MAX =
        (AW'(64'sd1) <<< (VALUE_WIDTH - 1)) - AW'(64'sd1);
    localparam logic signed [AW-1:0] VAL_MIN = -VAL_MAX - AW'(64'sd1);
    localparam logic [AW-1:0] NEG_LIMIT = AW'(64'd1) << (VALUE_WIDTH - 1);

    logic [2:0]              policy_reg;

    logic                    pend_valid_reg, pend_valid_next;
    logic [INDEX_WIDTH-1:0]  pend_row_reg, pend_row_next;
    logic [INDEX_WIDTH-1:0]  pend_col_reg, pend_col_next;
    logic signed [AW-1:0]    pend_acc_reg, pend_acc_next;
    logic [COUNT_WIDTH-1:0]  pend_cnt_reg, pend_cnt_next;

    logic [INDEX_WIDTH-1:0]  snap_row_reg, snap_row_next;
    logic [INDEX_WIDTH-1:0]  snap_col_reg, snap_col_next;
    logic signed [AW-1:0]    snap_acc_reg, snap_acc_next;
    logic [COUNT_WIDTH-1:0]  snap_cnt_reg, snap_cnt_next;
    logic                    snap_end_reg, snap_end_next;

    logic                    out_valid_reg, out_valid_next;
    logic [INDEX_WIDTH-1:0]  out_row_reg;
    logic [INDEX_WIDTH-1:0]  out_col_reg;
    logic [VALUE_WIDTH-1:0]  out_value_reg, out_value_next;
    logic [COUNT_WIDTH-1:0]  out_cnt_reg;
    logic                    out_end_reg;

    logic signed [AW-1:0]    val_ext;
    logic signed [AW-1:0]    acc_sum;
    logic                    sum_ovf;
    logic signed [AW-1:0]    acc_merged;
    logic [COUNT_WIDTH-1:0]  cnt_merged;
    logic                    match;
    logic [AW-1:0]           snap_mag;
    logic [AW-1:0]           quotient;
    logic [AW-1:0]           quotient_neg;
    logic                    div_busy;
    logic                    div_done;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= cdm_pkg::POL_SUM;
        end else if (cfg_wr_en) begin
            policy_reg <= cfg_wr_data;
        end
    end

    assign val_ext = {{(AW - VALUE_WIDTH){in_value[VALUE_WIDTH-1]}}, in_value};
    assign match   = pend_valid_reg && (pend_row_reg == in_row) && (pend_col_reg == in_col);

    // Saturating accumulate: overflow only when both operands share a sign.
    assign acc_sum = pend_acc_reg + val_ext;
    assign sum_ovf = (pend_acc_reg[AW-1] == val_ext[AW-1]) &&
                     (acc_sum[AW-1] != pend_acc_reg[AW-1]);

    always_comb begin
        case (policy_reg)
            cdm_pkg::POL_MAX:  acc_merged = (val_ext > pend_acc_reg) ? val_ext : pend_acc_reg;
            cdm_pkg::POL_MIN:  acc_merged = (val_ext < pend_acc_reg) ? val_ext : pend_acc_reg;
            cdm_pkg::POL_LAST: acc_merged = val_ext;
            default: begin
                if (sum_ovf) begin
                    acc_merged = pend_acc_reg[AW-1] ? ACC_MIN : ACC_MAX;
                end else begin
                    acc_merged = acc_sum;
                end
            end
        endcase
    end

    assign cnt_merged = (&pend_cnt_reg) ? pend_cnt_reg : pend_cnt_reg + COUNT_WIDTH'(1);

    // Pending entry and result snapshot.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        pend_acc_next   = pend_acc_reg;
        pend_cnt_next   = pend_cnt_reg;
        snap_row_next   = snap_row_reg;
        snap_col_next   = snap_col_reg;
        snap_acc_next   = snap_acc_reg;
        snap_cnt_next   = snap_cnt_reg;
        snap_end_next   = snap_end_reg;
        if (cmd.accept) begin
            if (match) begin
                if (in_final) begin
                    snap_row_next   = pend_row_reg;
                    snap_col_next   = pend_col_reg;
                    snap_acc_next   = acc_merged;
                    snap_cnt_next   = cnt_merged;
                    snap_end_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end else begin
                    pend_acc_next = acc_merged;
                    pend_cnt_next = cnt_merged;
                end
            end else begin
                if (pend_valid_reg) begin
                    snap_row_next = pend_row_reg;
                    snap_col_next = pend_col_reg;
                    snap_acc_next = pend_acc_reg;
                    snap_cnt_next = pend_cnt_reg;
                    snap_end_next = 1'b0;
                end
                if (in_final && !pend_valid_reg) begin
                    // A lone final word is emitted directly.
                    snap_row_next   = in_row;
                    snap_col_next   = in_col;
                    snap_acc_next   = val_ext;
                    snap_cnt_next   = COUNT_WIDTH'(1);
                    snap_end_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end else begin
                    pend_valid_next = 1'b1;
                    pend_row_next   = in_row;
                    pend_col_next   = in_col;
                    pend_acc_next   = val_ext;
                    pend_cnt_next   = COUNT_WIDTH'(1);
                end
            end
        end else if (cmd.snap_final) begin
            snap_row_next   = pend_row_reg;
            snap_col_next   = pend_col_reg;
            snap_acc_next   = pend_acc_reg;
            snap_cnt_next   = pend_cnt_reg;
            snap_end_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_row_reg <= pend_row_next;
        pend_col_reg <= pend_col_next;
        pend_acc_reg <= pend_acc_next;
        pend_cnt_reg <= pend_cnt_next;
        snap_row_reg <= snap_row_next;
        snap_col_reg <= snap_col_next;
        snap_acc_reg <= snap_acc_next;
        snap_cnt_reg <= snap_cnt_next;
        snap_end_reg <= snap_end_next;
    end

    // The average divides the magnitude and restores the sign afterwards.
    assign snap_mag = snap_acc_reg[AW-1] ? (AW'(0) - AW'(snap_acc_reg)) : AW'(snap_acc_reg);

    cdm_divider #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (snap_mag),
        .divisor  (snap_cnt_reg),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    assign quotient_neg = AW'(0) - quotient;

    always_comb begin
        if (cmd.sel_div) begin
            if (snap_acc_reg[AW-1]) begin
                out_value_next = (quotient > NEG_LIMIT) ? VAL_MIN[VALUE_WIDTH-1:0]
                                                        : quotient_neg[VALUE_WIDTH-1:0];
            end else begin
                out_value_next = (quotient > AW'(VAL_MAX)) ? VAL_MAX[VALUE_WIDTH-1:0]
                                                           : quotient[VALUE_WIDTH-1:0];
            end
        end else if (snap_acc_reg > VAL_MAX) begin
            out_value_next = VAL_MAX[VALUE_WIDTH-1:0];
        end else if (snap_acc_reg < VAL_MIN) begin
            out_value_next = VAL_MIN[VALUE_WIDTH-1:0];
        end else begin
            out_value_next = snap_acc_reg[VALUE_WIDTH-1:0];
        end
    end

    // Output register.
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_row_reg   <= snap_row_reg;
            out_col_reg   <= snap_col_reg;
            out_value_reg <= out_value_next;
            out_cnt_reg   <= snap_cnt_reg;
            out_end_reg   <= snap_end_reg;
        end
    end

    assign status.snap_taken = match ? in_final : (pend_valid_reg || in_final);
    assign status.fin_later  = !match && pend_valid_reg && in_final;
    assign status.policy_avg = (policy_reg == cdm_pkg::POL_AVG);
    assign status.div_done   = div_done;
    assign status.div_busy   = div_busy;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_count = out_cnt_reg;
    assign out_end   = out_end_reg;

endmodule

@@ rtl/coo_duplicate_merge_unit.sv @@
// Top level of the sparse COO duplicate merge unit.
//
// The slave stream carries sorted matrix entries, one word per entry: row and
// column coordinates and a signed fixed-point value in tdata, and tlast on the
// last entry of the stream. The unit keeps one pending entry and folds each
// word with the same coordinate into it under the policy held in the
// configuration register (sum, average, maximum, minimum or keep last; the
// unused codes act as sum). A word with a new coordinate, or the tlast word,
// sends the merged entry out on the master stream with its duplicate count;
// the entry that closes the stream is sent with tlast set.
// A word that only merges is taken in the idle state. A word that produces a
// result moves to a calculate state, which also forms a second, final result
// when one is needed. Under the average policy every result goes through a
// one-bit-per-cycle divider over the 64-bit running sum. The output is a
// register: the next word is accepted while a finished result waits, but
// s_tready drops while a result is being formed and m_tready is low with the
// output register still full.
// Reset clears the pending entry, the output register and sets the sum policy.
`include "coo_duplicate_merge_unit_defines.svh"

module coo_duplicate_merge_unit #(
    parameter int INDEX_WIDTH = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 32,
    localparam int S_DATA_W = ((2 * INDEX_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * INDEX_WIDTH + VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration: merge policy.
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_data,
    // Input entries.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // row_index, col_index, entry_value, zero pad
    input  logic                s_tlast,  // is_final
    // Merged entries.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // out_row, out_col, out_value, merged_count, zero pad
    output logic                m_tlast   // stream_end
);

    cdm_pkg::cdm_cmd_t     ctrl_cmd;
    cdm_pkg::cdm_status_t  dp_status;

    logic [INDEX_WIDTH-1:0] out_row;
    logic [INDEX_WIDTH-1:0] out_col;
    logic [VALUE_WIDTH-1:0] out_value;
    logic [COUNT_WIDTH-1:0] out_count;

    // The controller owns the handshake on the input side; the datapath owns
    // the output register and its valid flag.
    cdm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    cdm_datapath #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_row      (s_tdata[INDEX_WIDTH-1:0]),
        .in_col      (s_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH]),
        .in_value    (s_tdata[2*INDEX_WIDTH+VALUE_WIDTH-1:2*INDEX_WIDTH]),
        .in_final    (s_tlast),
        .cmd         (ctrl_cmd),
        .status      (dp_status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .out_count   (out_count),
        .out_end     (m_tlast)
    );

    // Pack the result fields from the lowest bit up; the size cast zero-fills.
    assign m_tdata = M_DATA_W'({out_count, out_value, out_col, out_row});

    // The output register is only loaded when it is empty or being drained.
    `CDM_ASSERT_IMP(a_load_when_free, ctrl_cmd.load_out, (!m_tvalid || m_tready), "output overwritten while stalled")
    // A load always shows up as a valid result on the next cycle.
    `CDM_ASSERT_NEXT(a_load_shows, ctrl_cmd.load_out, m_tvalid, "loaded result not presented")
    // New words are only taken while the divider is quiet.
    `CDM_ASSERT_IMP(a_ready_div_idle, s_tready, !dp_status.div_busy, "input accepted during a division")

endmodule
